// ===== rtl/core/sha_pkg.sv =====
// Shared types, constants and subregion geometry for the subregion heap allocator.
// No dependencies; imported by sha_search and subregion_heap_allocator.
package sha_pkg;

    localparam int NUM_SUBREGIONS = 40;
    localparam int TABLE_ENTRIES  = 12;
    localparam int SUB_W          = 6;
    localparam int OWN_W          = 4;
    localparam int UNIT_W         = 8;
    localparam int EIDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int IN_TDATA_W     = 56;
    localparam int OUT_TDATA_W    = 64;
    localparam int CFG_AW         = 4;
    localparam int CFG_DW         = 64;

    localparam logic [SUB_W-1:0]          NO_START      = 6'd40;
    localparam logic [SUB_W-1:0]          LAST_SUB      = 6'd39;
    localparam logic [OWN_W-1:0]          EMPTY_OWNER   = 4'd12;
    localparam logic [31:0]               HEAP_BASE_RST = 32'h2000_1000;
    localparam logic [NUM_SUBREGIONS-1:0] LOCKED_RST    = 40'h01_8001_8180;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOSPACE  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FAULT    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_FIND  = 2'd2,
        OP_RSVD  = 2'd3
    } t_opcode;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [SUB_W-1:0] first;
        logic [SUB_W-1:0] cnt;
    } t_srch_res;

    // size of one subregion in 512-byte units
    function automatic logic [1:0] sub_units(input logic [SUB_W-1:0] s);
        return (s inside {[6'd0:6'd7], [6'd16:6'd31]}) ? 2'd1 : 2'd2;
    endfunction

    // offset of subregion s in 512-byte units, clamped at the heap end
    function automatic logic [6:0] sub_off(input logic [6:0] s);
        logic [6:0] r;
        if (s <= 7'd8) begin
            r = s;
        end else if (s <= 7'd16) begin
            r = {s[5:0], 1'b0} - 7'd8;
        end else if (s <= 7'd32) begin
            r = s + 7'd8;
        end else if (s <= 7'd40) begin
            r = {s[5:0], 1'b0} - 7'd24;
        end else begin
            r = 7'd56;
        end
        return r;
    endfunction

    // subregion whose base lies at byte offset diff, NO_START if none
    function automatic logic [SUB_W-1:0] addr_sub(input logic [31:0] diff);
        logic [22:0]      u;
        logic [SUB_W-1:0] r;
        u = diff[31:9];
        r = NO_START;
        if (diff[8:0] == 9'd0 && u < 23'd56) begin
            if (u < 23'd8) begin
                r = u[5:0];
            end else if (u < 23'd24) begin
                if (!u[0]) r = {1'b0, u[5:1]} + 6'd4;
            end else if (u < 23'd40) begin
                r = u[5:0] - 6'd8;
            end else begin
                if (!u[0]) r = {1'b0, u[5:1]} + 6'd12;
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/sha_search.sv =====
// Run search sequencer: walks the free map one subregion per cycle outside drop
// steps, with one shared add/subtract unit. Depends on sha_pkg.
module sha_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [sha_pkg::UNIT_W-1:0]         i_units,
    input  logic [sha_pkg::NUM_SUBREGIONS-1:0] i_free_map,
    input  logic [sha_pkg::NUM_SUBREGIONS-1:0] i_locked_mask,
    output sha_pkg::t_srch_res                 o_res
);
    import sha_pkg::*;

    typedef enum logic [1:0] {
        SR_IDLE,
        SR_ODD,
        SR_PASS,
        SR_DROP
    } t_state;

    t_state            r_state;
    logic [1:0]        r_walk;
    logic [1:0]        r_pass;
    logic [SUB_W-1:0]  r_s;
    logic [SUB_W-1:0]  r_k;
    logic [UNIT_W-1:0] r_sum;
    logic [UNIT_W-1:0] r_units;
    t_srch_res         r_res;

    logic [UNIT_W-1:0] add_b;
    logic [UNIT_W-1:0] nsum;
    logic              k_in;
    logic              k_free;
    logic              k_locked;
    logic [1:0]        k_size;
    logic              pass_ok;
    logic              elig;
    logic              up;
    logic [SUB_W-1:0]  ws;
    logic [SUB_W-1:0]  ws_next;

    function automatic logic [SUB_W-1:0] walk_start(input logic [1:0] w);
        logic [SUB_W-1:0] r;
        case (w)
            2'd0:    r = 6'd7;
            2'd1:    r = 6'd16;
            default: r = 6'd31;
        endcase
        return r;
    endfunction

    always_comb begin
        k_size   = sub_units(r_k);
        k_in     = (r_k < NO_START);
        k_free   = k_in && i_free_map[r_k];
        k_locked = k_in && i_locked_mask[r_k];
        case (r_pass)
            2'd0:    pass_ok = !k_locked && (k_size == 2'd1);
            2'd1:    pass_ok = !k_locked && (k_size == 2'd2);
            2'd2:    pass_ok = !k_locked;
            default: pass_ok = 1'b1;
        endcase
        elig    = k_free && pass_ok;
        up      = (r_walk != 2'd1);
        ws      = walk_start(r_walk);
        ws_next = walk_start(r_walk + 2'd1);
        add_b   = (r_state == SR_DROP) ? (~{6'd0, sub_units(r_s)} + 8'd1) : {6'd0, k_size};
        nsum    = r_sum + add_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SR_IDLE;
            r_res   <= '0;
        end else begin
            r_res.done <= 1'b0;
            case (r_state)
                SR_IDLE: begin
                    if (i_start) begin
                        r_units <= i_units;
                        r_sum   <= '0;
                        if (i_units[0] && i_units != 8'd1) begin
                            r_state <= SR_ODD;
                            r_walk  <= 2'd0;
                            r_k     <= walk_start(2'd0);
                        end else begin
                            r_state <= SR_PASS;
                            r_pass  <= (i_units == 8'd1) ? 2'd0 :
                                       (i_units == 8'd2) ? 2'd1 : 2'd2;
                            r_s     <= '0;
                            r_k     <= '0;
                        end
                    end
                end
                SR_ODD: begin
                    if (k_free && nsum == r_units) begin
                        r_state     <= SR_IDLE;
                        r_res.done  <= 1'b1;
                        r_res.found <= 1'b1;
                        r_res.first <= up ? ws : r_k;
                        r_res.cnt   <= up ? (r_k - ws + 6'd1) : (ws - r_k + 6'd1);
                    end else if (!k_free || nsum > r_units ||
                                 (up ? (r_k == LAST_SUB) : (r_k == 6'd0))) begin
                        if (r_walk == 2'd2) begin
                            r_state     <= SR_IDLE;
                            r_res.done  <= 1'b1;
                            r_res.found <= 1'b0;
                            r_res.first <= NO_START;
                            r_res.cnt   <= '0;
                        end else begin
                            r_walk <= r_walk + 2'd1;
                            r_k    <= ws_next;
                            r_sum  <= '0;
                        end
                    end else begin
                        r_sum <= nsum;
                        r_k   <= up ? (r_k + 6'd1) : (r_k - 6'd1);
                    end
                end
                SR_PASS: begin
                    if (!elig) begin
                        if (r_k >= LAST_SUB) begin
                            if (r_pass == 2'd3) begin
                                r_state     <= SR_IDLE;
                                r_res.done  <= 1'b1;
                                r_res.found <= 1'b0;
                                r_res.first <= NO_START;
                                r_res.cnt   <= '0;
                            end else begin
                                r_pass <= r_pass + 2'd1;
                                r_s    <= '0;
                                r_k    <= '0;
                                r_sum  <= '0;
                            end
                        end else begin
                            r_s   <= r_k + 6'd1;
                            r_k   <= r_k + 6'd1;
                            r_sum <= '0;
                        end
                    end else if (nsum == r_units) begin
                        r_state     <= SR_IDLE;
                        r_res.done  <= 1'b1;
                        r_res.found <= 1'b1;
                        r_res.first <= r_s;
                        r_res.cnt   <= r_k - r_s + 6'd1;
                    end else if (nsum > r_units) begin
                        r_state <= SR_DROP;
                    end else begin
                        r_sum <= nsum;
                        r_k   <= r_k + 6'd1;
                    end
                end
                SR_DROP: begin
                    r_state <= SR_PASS;
                    if (r_s == r_k) begin
                        r_s   <= r_k + 6'd1;
                        r_k   <= r_k + 6'd1;
                        r_sum <= '0;
                    end else begin
                        r_s   <= r_s + 6'd1;
                        r_sum <= nsum;
                    end
                end
                default: r_state <= SR_IDLE;
            endcase
        end
    end

    assign o_res = r_res;

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res.done |=> !r_res.done)
        else $error("search done held longer than one cycle");

    a_run_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res.done && r_res.found) |->
            ({1'b0, r_res.first} + {1'b0, r_res.cnt}) <= 7'd40 && r_res.cnt != 6'd0)
        else $error("search run leaves the heap");

    a_odd_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SR_ODD) |-> (r_k < NO_START))
        else $error("odd-size walk left the subregion range");

endmodule

// ===== rtl/core/subregion_heap_allocator.sv =====
// Top level of the subregion heap allocator: stream ports, APB register port,
// owner table and free map. Depends on sha_pkg and sha_search.
//
// Usage: a request enters on s_axis; tuser carries the opcode (allocate, free,
// find). One result per request leaves on m_axis, holding status, base address,
// byte length, first subregion and subregion count.
// Allocate runs the search unit, one subregion step per cycle: up to three
// walks for odd sizes above 512 bytes and up to four passes for other sizes,
// then a scan of the owner table. Free and find scan the table one entry per
// cycle. s_axis_tready is high only while no request is in work. A finished
// result sits in the output register; the next request is taken while it
// waits. If m_axis stalls, the following result holds in its final step until
// the output register empties.
// Reset (synchronous, active low) frees every subregion, empties the table and
// loads the register reset values. The user writes the registers over APB only
// while idle; the block itself does not enforce this.
module subregion_heap_allocator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [15:0] req_bytes, [19:16] task_id, [51:20] address, [55:52] zero
    input  logic [sha_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] status, [34:3] base_address, [49:35] byte_length,
    // [55:50] first_subregion, [61:56] subregion_count, [63:62] zero
    output logic [sha_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sha_pkg::CFG_AW-1:0]       paddr,
    input  logic [sha_pkg::CFG_DW-1:0]       pwdata,
    output logic [sha_pkg::CFG_DW-1:0]       prdata,
    output logic                             pready
);
    import sha_pkg::*;

    localparam logic REG_HEAP_BASE = 1'b0;
    localparam logic REG_LOCKED    = 1'b1;

    typedef enum logic [2:0] {
        T_IDLE,
        T_SRCH,
        T_ALLOC_SCAN,
        T_FREE_SCAN,
        T_FIND_SCAN,
        T_RESULT
    } t_state;

    t_state                    r_state;
    logic [31:0]               r_heap_base;
    logic [NUM_SUBREGIONS-1:0] r_locked;
    logic [NUM_SUBREGIONS-1:0] r_free_map;
    logic [SUB_W-1:0]          r_ent_start [TABLE_ENTRIES];
    logic [SUB_W-1:0]          r_ent_count [TABLE_ENTRIES];
    logic [OWN_W-1:0]          r_ent_owner [TABLE_ENTRIES];
    logic [EIDX_W-1:0]         r_eidx;
    logic [OWN_W-1:0]          r_task;
    logic [SUB_W-1:0]          r_fsub;
    logic [UNIT_W-1:0]         r_units;
    logic                      r_srch_start;
    t_status                   r_status;
    logic [SUB_W-1:0]          r_first;
    logic [SUB_W-1:0]          r_cnt;
    logic                      r_mvalid;
    logic [OUT_TDATA_W-1:0]    r_mdata;

    t_srch_res                 srch_res;
    logic                      in_xfer;
    t_opcode                   in_op;
    logic [15:0]               in_req;
    logic [OWN_W-1:0]          in_task;
    logic [31:0]               in_addr;
    logic [16:0]               in_round;
    logic [SUB_W-1:0]          in_fsub;
    logic [SUB_W-1:0]          cur_start;
    logic [SUB_W-1:0]          cur_count;
    logic [OWN_W-1:0]          cur_owner;
    logic                      eidx_last;
    logic [NUM_SUBREGIONS-1:0] clr_mask;
    logic [6:0]                off_first;
    logic [6:0]                off_end;
    logic [6:0]                len_units;
    logic [31:0]               res_base;
    logic [14:0]               res_len;
    logic                      out_free;
    logic                      cfg_wr;

    function automatic logic [NUM_SUBREGIONS-1:0] run_mask(input logic [SUB_W-1:0] first,
                                                           input logic [SUB_W-1:0] cnt);
        logic [NUM_SUBREGIONS-1:0] m;
        logic [6:0]                hi;
        hi = {1'b0, first} + {1'b0, cnt};
        for (int i = 0; i < NUM_SUBREGIONS; i++) begin
            m[i] = (7'(i) >= {1'b0, first}) && (7'(i) < hi);
        end
        return m;
    endfunction

    sha_search u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (r_srch_start),
        .i_units       (r_units),
        .i_free_map    (r_free_map),
        .i_locked_mask (r_locked),
        .o_res         (srch_res)
    );

    always_comb begin
        in_xfer   = s_axis_tvalid && s_axis_tready;
        in_op     = t_opcode'(s_axis_tuser);
        in_req    = s_axis_tdata[15:0];
        in_task   = s_axis_tdata[19:16];
        in_addr   = s_axis_tdata[51:20];
        in_round  = {1'b0, in_req} + 17'd511;
        in_fsub   = addr_sub(in_addr - r_heap_base);
        cur_start = r_ent_start[r_eidx];
        cur_count = r_ent_count[r_eidx];
        cur_owner = r_ent_owner[r_eidx];
        eidx_last = (r_eidx == EIDX_W'(TABLE_ENTRIES - 1));
        clr_mask  = (r_state == T_FREE_SCAN) ? run_mask(cur_start, cur_count)
                                             : run_mask(r_first, r_cnt);
        off_first = sub_off({1'b0, r_first});
        off_end   = sub_off({1'b0, r_first} + {1'b0, r_cnt});
        len_units = off_end - off_first;
        res_base  = r_heap_base + {16'd0, off_first, 9'd0};
        res_len   = {len_units[5:0], 9'd0};
        out_free  = !r_mvalid || m_axis_tready;
        cfg_wr    = psel && penable && pwrite;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= HEAP_BASE_RST;
            r_locked    <= LOCKED_RST;
        end else if (cfg_wr) begin
            case (paddr[3])
                REG_HEAP_BASE: r_heap_base <= pwdata[31:0];
                REG_LOCKED:    r_locked    <= pwdata[NUM_SUBREGIONS-1:0];
                default:       r_heap_base <= r_heap_base;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_HEAP_BASE: prdata = {32'd0, r_heap_base};
            REG_LOCKED:    prdata = {24'd0, r_locked};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= T_IDLE;
            r_srch_start <= 1'b0;
            r_mvalid     <= 1'b0;
            r_free_map   <= '1;
            for (int e = 0; e < TABLE_ENTRIES; e++) begin
                r_ent_start[e] <= NO_START;
                r_ent_count[e] <= '0;
                r_ent_owner[e] <= EMPTY_OWNER;
            end
        end else begin
            r_srch_start <= 1'b0;
            if (r_mvalid && m_axis_tready) r_mvalid <= 1'b0;
            case (r_state)
                T_IDLE: begin
                    if (in_xfer) begin
                        r_task <= in_task;
                        r_eidx <= '0;
                        case (in_op)
                            OP_ALLOC: begin
                                r_units <= in_round[16:9];
                                if (in_req == 16'd0 || in_task >= EMPTY_OWNER) begin
                                    r_status <= ST_NOSPACE;
                                    r_state  <= T_RESULT;
                                end else begin
                                    r_srch_start <= 1'b1;
                                    r_state      <= T_SRCH;
                                end
                            end
                            OP_FREE: begin
                                r_fsub <= in_fsub;
                                if (in_fsub == NO_START) begin
                                    r_status <= ST_NOTFOUND;
                                    r_state  <= T_RESULT;
                                end else begin
                                    r_state <= T_FREE_SCAN;
                                end
                            end
                            OP_FIND: begin
                                if (in_task >= EMPTY_OWNER) begin
                                    r_status <= ST_NOTFOUND;
                                    r_state  <= T_RESULT;
                                end else begin
                                    r_state <= T_FIND_SCAN;
                                end
                            end
                            default: begin
                                r_status <= ST_NOSPACE;
                                r_state  <= T_RESULT;
                            end
                        endcase
                    end
                end
                T_SRCH: begin
                    if (srch_res.done) begin
                        r_first <= srch_res.first;
                        r_cnt   <= srch_res.cnt;
                        if (srch_res.found) begin
                            r_state <= T_ALLOC_SCAN;
                        end else begin
                            r_status <= ST_NOSPACE;
                            r_state  <= T_RESULT;
                        end
                    end
                end
                T_ALLOC_SCAN: begin
                    if (cur_owner == EMPTY_OWNER) begin
                        r_ent_start[r_eidx] <= r_first;
                        r_ent_count[r_eidx] <= r_cnt;
                        r_ent_owner[r_eidx] <= r_task;
                        r_free_map          <= r_free_map & ~clr_mask;
                        r_status            <= ST_OK;
                        r_state             <= T_RESULT;
                    end else if (eidx_last) begin
                        r_status <= ST_FULL;
                        r_state  <= T_RESULT;
                    end else begin
                        r_eidx <= r_eidx + 1'b1;
                    end
                end
                T_FREE_SCAN: begin
                    if (cur_owner != EMPTY_OWNER && cur_start == r_fsub) begin
                        r_state <= T_RESULT;
                        if (cur_owner != r_task) begin
                            r_status <= ST_FAULT;
                        end else begin
                            r_status            <= ST_OK;
                            r_first             <= cur_start;
                            r_cnt               <= cur_count;
                            r_free_map          <= r_free_map | clr_mask;
                            r_ent_start[r_eidx] <= NO_START;
                            r_ent_count[r_eidx] <= '0;
                            r_ent_owner[r_eidx] <= EMPTY_OWNER;
                        end
                    end else if (eidx_last) begin
                        r_status <= ST_NOTFOUND;
                        r_state  <= T_RESULT;
                    end else begin
                        r_eidx <= r_eidx + 1'b1;
                    end
                end
                T_FIND_SCAN: begin
                    if (cur_owner == r_task) begin
                        r_status <= ST_OK;
                        r_first  <= cur_start;
                        r_cnt    <= cur_count;
                        r_state  <= T_RESULT;
                    end else if (eidx_last) begin
                        r_status <= ST_NOTFOUND;
                        r_state  <= T_RESULT;
                    end else begin
                        r_eidx <= r_eidx + 1'b1;
                    end
                end
                T_RESULT: begin
                    if (out_free) begin
                        r_mvalid <= 1'b1;
                        r_state  <= T_IDLE;
                        if (r_status == ST_OK) begin
                            r_mdata <= {2'd0, r_cnt, r_first, res_len, res_base, r_status};
                        end else begin
                            r_mdata <= {2'd0, 6'd0, NO_START, 15'd0, 32'd0, r_status};
                        end
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == T_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign pready        = 1'b1;

    a_srch_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        srch_res.done |-> (r_state == T_SRCH))
        else $error("search finished while no allocation waits for it");

    a_result_from_final_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_mvalid) |-> ($past(r_state) == T_RESULT))
        else $error("result loaded outside the result step");

    a_alloc_claims_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_ALLOC_SCAN && cur_owner == EMPTY_OWNER)
            |=> ((r_free_map & $past(clr_mask)) == '0))
        else $error("allocated run still marked free");

endmodule

// ===== test/tb_subregion_heap_allocator.sv =====
// Self-checking testbench for subregion_heap_allocator: predicts every reply from its own
// copy of the free map, owner table and registers, and checks each result transfer.
// Depends on sha_pkg and the allocator RTL only.
module tb_subregion_heap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import sha_pkg::*;

    localparam logic [CFG_AW-1:0] REG_HEAP_BASE   = 4'h0;
    localparam logic [CFG_AW-1:0] REG_LOCKED_MASK = 4'h8;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int HOLDOFF_CYCLES = 600;
    localparam int TAIL_CYCLES    = 400;

    typedef enum int {PASS_SMALL, PASS_LARGE, PASS_UNLOCKED, PASS_ANY} search_pass_t;

    // status in the low bits, as on m_axis_tdata
    typedef struct packed {
        logic [5:0]  cnt;
        logic [5:0]  first;
        logic [14:0] len;
        logic [31:0] base;
        logic [2:0]  status;
    } heap_reply_t;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   s_axis_tvalid  = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic [1:0]             s_axis_tuser   = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel           = 1'b0;
    logic                   penable        = 1'b0;
    logic                   pwrite         = 1'b0;
    logic [CFG_AW-1:0]      paddr          = '0;
    logic [CFG_DW-1:0]      pwdata         = '0;
    logic [CFG_DW-1:0]      prdata;
    logic                   pready;

    subregion_heap_allocator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    logic [31:0]               base_reg;
    logic [NUM_SUBREGIONS-1:0] lock_reg;
    logic [NUM_SUBREGIONS-1:0] free_bits;
    logic [SUB_W-1:0]          ent_first [TABLE_ENTRIES];
    logic [SUB_W-1:0]          ent_len   [TABLE_ENTRIES];
    logic [OWN_W-1:0]          ent_owner [TABLE_ENTRIES];

    heap_reply_t pending_outcomes[$];
    int mismatches       = 0;
    int cycle_count      = 0;
    int send_idle_pct    = 0;
    int recv_idle_pct    = 0;
    int holdoff_requests = 0;
    int holdoff_seen     = 0;
    int holdoff_left     = 0;

    function automatic int sub_bytes(int s);
        return (s <= 7 || (s >= 16 && s <= 31)) ? 512 : 1024;
    endfunction

    function automatic int byte_offset(int s);
        int off;
        off = 0;
        for (int i = 0; i < s && i < NUM_SUBREGIONS; i++) off += sub_bytes(i);
        return off;
    endfunction

    function automatic bit pass_allows(int pass, int s);
        bit locked;
        locked = lock_reg[s];
        case (pass)
            PASS_SMALL:    return !locked && sub_bytes(s) == 512;
            PASS_LARGE:    return !locked && sub_bytes(s) == 1024;
            PASS_UNLOCKED: return !locked;
            default:       return 1'b1;
        endcase
    endfunction

    function automatic bit find_run(input int size, output int first, output int cnt);
        int starts[3] = '{7, 16, 31};
        int p, sum, dir, pass;
        first = NO_START;
        cnt = 0;
        if (size > 512 && size % 1024 == 512) begin
            for (int w = 0; w < 3; w++) begin
                dir = (w == 1) ? -1 : 1;
                p = starts[w];
                sum = 0;
                while (p >= 0 && p < NUM_SUBREGIONS && free_bits[p]) begin
                    sum += sub_bytes(p);
                    if (sum == size) begin
                        first = (dir > 0) ? starts[w] : p;
                        cnt = (dir > 0) ? p - starts[w] + 1 : starts[w] - p + 1;
                        return 1'b1;
                    end
                    if (sum > size) break;
                    p += dir;
                end
            end
            return 1'b0;
        end
        pass = (size == 512) ? PASS_SMALL : (size == 1024) ? PASS_LARGE : PASS_UNLOCKED;
        for (; pass <= PASS_ANY; pass++) begin
            for (int s = 0; s < NUM_SUBREGIONS; s++) begin
                sum = 0;
                for (int k = s; k < NUM_SUBREGIONS && free_bits[k] && pass_allows(pass, k);
                     k++) begin
                    sum += sub_bytes(k);
                    if (sum == size) begin
                        first = s;
                        cnt = k - s + 1;
                        return 1'b1;
                    end
                    if (sum > size) break;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic heap_reply_t reply_for(t_status st, int first, int cnt);
        heap_reply_t r;
        r = '0;
        r.status = st;
        r.first = NO_START;
        if (st == ST_OK) begin
            r.base  = base_reg + 32'(byte_offset(first));
            r.len   = 15'(byte_offset(first + cnt) - byte_offset(first));
            r.first = 6'(first);
            r.cnt   = 6'(cnt);
        end
        return r;
    endfunction

    function automatic heap_reply_t heap_outcome(t_opcode op, logic [15:0] req,
                                                 logic [OWN_W-1:0] tid, logic [31:0] addr);
        int size, first, cnt, e, s;
        logic [31:0] sub_addr;
        case (op)
            OP_ALLOC: begin
                size = ((int'(req) + 511) / 512) * 512;
                if (req == 0 || tid >= EMPTY_OWNER || !find_run(size, first, cnt))
                    return reply_for(ST_NOSPACE, 0, 0);
                for (e = 0; e < TABLE_ENTRIES && ent_owner[e] != EMPTY_OWNER; e++) begin
                end
                if (e >= TABLE_ENTRIES) return reply_for(ST_FULL, 0, 0);
                ent_first[e] = 6'(first);
                ent_len[e]   = 6'(cnt);
                ent_owner[e] = tid;
                for (int i = first; i < first + cnt && i < NUM_SUBREGIONS; i++)
                    free_bits[i] = 1'b0;
                return reply_for(ST_OK, first, cnt);
            end
            OP_FREE: begin
                for (s = 0; s < NUM_SUBREGIONS; s++) begin
                    sub_addr = base_reg + 32'(byte_offset(s));
                    if (sub_addr == addr) break;
                end
                if (s < NUM_SUBREGIONS) begin
                    for (e = 0; e < TABLE_ENTRIES; e++) begin
                        if (ent_owner[e] == EMPTY_OWNER || ent_first[e] != s) continue;
                        if (ent_owner[e] != tid) return reply_for(ST_FAULT, 0, 0);
                        first = ent_first[e];
                        cnt = ent_len[e];
                        for (int i = first; i < first + cnt && i < NUM_SUBREGIONS; i++)
                            free_bits[i] = 1'b1;
                        ent_first[e] = NO_START;
                        ent_len[e]   = '0;
                        ent_owner[e] = EMPTY_OWNER;
                        return reply_for(ST_OK, first, cnt);
                    end
                end
                return reply_for(ST_NOTFOUND, 0, 0);
            end
            OP_FIND: begin
                for (e = 0; e < TABLE_ENTRIES; e++)
                    if (tid < EMPTY_OWNER && ent_owner[e] == tid)
                        return reply_for(ST_OK, ent_first[e], ent_len[e]);
                return reply_for(ST_NOTFOUND, 0, 0);
            end
            default: return reply_for(ST_NOSPACE, 0, 0);
        endcase
    endfunction

    function automatic void clear_heap_model();
        base_reg  = HEAP_BASE_RST;
        lock_reg  = LOCKED_RST;
        free_bits = '1;
        for (int e = 0; e < TABLE_ENTRIES; e++) begin
            ent_first[e] = NO_START;
            ent_len[e]   = '0;
            ent_owner[e] = EMPTY_OWNER;
        end
    endfunction

    function automatic logic [31:0] owned_base(int tid);
        for (int e = 0; e < TABLE_ENTRIES; e++)
            if (ent_owner[e] == tid) return base_reg + 32'(byte_offset(ent_first[e]));
        return base_reg;
    endfunction

    // called at a falling edge; leaves tvalid high for a following transfer
    task automatic send_request(t_opcode op, logic [15:0] req, logic [OWN_W-1:0] tid,
                                logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, addr, tid, req};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_outcomes.push_back(heap_outcome(op, req, tid, addr));
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending_outcomes.size() == 0);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_HEAP_BASE) base_reg = value[31:0];
        else lock_reg = value[NUM_SUBREGIONS-1:0];
    endtask

    task automatic set_config(logic [31:0] heap_base, logic [NUM_SUBREGIONS-1:0] locked);
        drain();
        write_reg(REG_HEAP_BASE, {32'b0, heap_base});
        write_reg(REG_LOCKED_MASK, {24'b0, locked});
    endtask

    task automatic send_random_request();
        int pick, e;
        int live[$];
        logic [15:0] req;
        logic [OWN_W-1:0] tid;
        logic [31:0] addr;
        t_opcode op;
        pick = $urandom_range(99);
        req  = 16'($urandom);
        tid  = 4'($urandom_range(0, 11));
        addr = $urandom;
        if ($urandom_range(19) == 0) tid = 4'($urandom_range(12, 15));
        if (pick < 45) begin
            op = OP_ALLOC;
            case ($urandom_range(19))
                0:       req = 16'd0;
                1, 2:    req = 16'($urandom);
                3:       req = 16'($urandom_range(1, 40) * 512 - $urandom_range(0, 511));
                default: req = 16'($urandom_range(1, 6) * 512 - $urandom_range(0, 511));
            endcase
        end else if (pick < 80) begin
            op = OP_FREE;
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (ent_owner[i] != EMPTY_OWNER) live.push_back(i);
            if (live.size() != 0 && $urandom_range(9) < 8) begin
                e = live[$urandom_range(0, live.size() - 1)];
                addr = base_reg + 32'(byte_offset(ent_first[e]));
                if ($urandom_range(9) != 0) tid = ent_owner[e];
            end else if ($urandom_range(1) == 0) begin
                addr = base_reg + 32'(byte_offset($urandom_range(0, NUM_SUBREGIONS)))
                     + (($urandom_range(3) == 0) ? $urandom_range(1, 1023) : 0);
            end
        end else if (pick < 96) begin
            op = OP_FIND;
        end else begin
            op = OP_RSVD;
        end
        send_request(op, req, tid, addr);
    endtask

    task automatic test_directed();
        send_request(OP_FIND, 16'd0, 4'd0, 32'd0);
        send_request(OP_ALLOC, 16'd28672, 4'd11, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 16'd512, 4'd0, 32'd0);
        send_request(OP_FREE, 16'hFFFF, 4'd11, owned_base(11));
        send_request(OP_ALLOC, 16'd0, 4'd0, 32'd0);
        send_request(OP_ALLOC, 16'hFFFF, 4'd0, 32'd0);
        send_request(OP_ALLOC, 16'd512, 4'd15, 32'd0);
        send_request(OP_ALLOC, 16'd1, 4'd0, 32'd0);
        send_request(OP_ALLOC, 16'd1024, 4'd1, 32'd0);
        send_request(OP_ALLOC, 16'd1536, 4'd2, 32'd0);
        send_request(OP_ALLOC, 16'd2048, 4'd3, 32'd0);
        send_request(OP_ALLOC, 16'd2560, 4'd4, 32'd0);
        send_request(OP_FIND, 16'hFFFF, 4'd2, 32'hFFFF_FFFF);
        send_request(OP_FIND, 16'd0, 4'd15, 32'd0);
        send_request(OP_FREE, 16'd0, 4'd5, owned_base(0));
        send_request(OP_FREE, 16'd0, 4'd0, base_reg + 32'd256);
        send_request(OP_FREE, 16'd0, 4'd0, 32'hFFFF_FFFF);
        send_request(OP_FREE, 16'd0, 4'd0, owned_base(0));
        send_request(OP_RSVD, 16'hFFFF, 4'd15, 32'hFFFF_FFFF);
        send_request(OP_FIND, 16'd0, 4'd0, 32'd0);
    endtask

    task automatic test_table_full();
        int used;
        for (int n = 0; n < TABLE_ENTRIES; n++) begin
            used = 0;
            for (int e = 0; e < TABLE_ENTRIES; e++)
                if (ent_owner[e] != EMPTY_OWNER) used++;
            if (used == TABLE_ENTRIES) break;
            send_request(OP_ALLOC, 16'd512, 4'(n % 12), $urandom);
        end
        send_request(OP_ALLOC, 16'd512, 4'd6, 32'd0);
        send_request(OP_ALLOC, 16'd1536, 4'd7, 32'd0);
    endtask

    task automatic test_random_phase(int count, int send_idle, int recv_idle);
        send_idle_pct = send_idle;
        recv_idle_pct = recv_idle;
        repeat (count) send_random_request();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff_requests++;
        repeat (12) send_random_request();
        drain();
    endtask

    always @(posedge i_clk) begin
        if (holdoff_seen != holdoff_requests) begin
            holdoff_seen <= holdoff_requests;
            holdoff_left <= HOLDOFF_CYCLES;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_field(string field, logic [31:0] want_v, logic [31:0] got_v);
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_outcomes
        heap_reply_t want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[61:0];
            if (pending_outcomes.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h",
                         $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_outcomes.pop_front();
                if (got.status !== want.status) report_field("status", want.status, got.status);
                if (got.base !== want.base) report_field("base_address", want.base, got.base);
                if (got.len !== want.len) report_field("byte_length", want.len, got.len);
                if (got.first !== want.first)
                    report_field("first_subregion", want.first, got.first);
                if (got.cnt !== want.cnt) report_field("subregion_count", want.cnt, got.cnt);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        clear_heap_model();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_table_full();
        test_random_phase(140, 21, 85);
        set_config(32'hFFFF_FFFF, '0);
        test_random_phase(140, 85, 21);
        set_config(32'h0, '1);
        test_random_phase(140, 0, 0);
        test_backpressure();
        set_config($urandom, NUM_SUBREGIONS'({$urandom, $urandom}));
        test_random_phase(130, 0, 0);
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
